// ===== design/sha256_pkg.sv =====
// Shared types and constants of the SHA-256 block compression unit.
// Holds the round constant table, the standard initial hash words and the queue item type.
// No dependencies.
package sha256_pkg;

  localparam int unsigned WordW      = 32;
  localparam int unsigned NumChain   = 8;
  localparam int unsigned BlockWords = 16;
  localparam int unsigned NumRounds  = 64;
  localparam int unsigned CountW     = $clog2(BlockWords);
  localparam int unsigned RoundW     = $clog2(NumRounds);
  localparam int unsigned CfgIdxW    = $clog2(NumChain);

  localparam logic [CountW-1:0] LastWordIdx = CountW'(BlockWords - 1);
  localparam logic [RoundW-1:0] LastRound   = RoundW'(NumRounds - 1);

  localparam logic [WordW-1:0] IvReset [NumChain] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [WordW-1:0] RoundK [NumRounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // One queued request: the message word and how it sits within its block.
  typedef struct packed {
    logic [WordW-1:0] word;
    logic             first;
    logic             last;
  } item_t;

  function automatic logic [WordW-1:0] big_sigma0(input logic [WordW-1:0] x);
    big_sigma0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [WordW-1:0] big_sigma1(input logic [WordW-1:0] x);
    big_sigma1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [WordW-1:0] small_sigma0(input logic [WordW-1:0] x);
    small_sigma0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [WordW-1:0] small_sigma1(input logic [WordW-1:0] x);
    small_sigma1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

// ===== design/sha256_block_compression.sv =====
// Top level of the SHA-256 block compression unit: front end, request queue and core.
// Depends on sha256_pkg, sha256_front, sha256_fifo and sha256_core.
//
//   channel   handshake            payload
//   input     start_i / busy_o     message_word_i, new_message_i
//   result    done_o (strobe)      digest_word_0_o .. digest_word_7_o
//   config    cfg_we_i             cfg_index_i, cfg_wdata_i
//
// Each word is taken while busy_o is low; the core drains one queued word per cycle while idle.
// The sixteenth word of a block starts the rounds and then the fold of the chaining value,
// all run by the single round unit, which drains no queued word until the fold is done.
// The strobe rises once the rounds and the FINISH fold after the last queued word are done, and lasts one cycle.
// busy_o rises only when the queue is full; reset restores the standard initial values.
module sha256_block_compression #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic [sha256_pkg::WordW-1:0]   message_word_i,
  input  logic                           new_message_i,
  input  logic                           cfg_we_i,
  input  logic [sha256_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [sha256_pkg::WordW-1:0]   cfg_wdata_i,
  output logic                           done_o,
  output logic [sha256_pkg::WordW-1:0]   digest_word_0_o,
  output logic [sha256_pkg::WordW-1:0]   digest_word_1_o,
  output logic [sha256_pkg::WordW-1:0]   digest_word_2_o,
  output logic [sha256_pkg::WordW-1:0]   digest_word_3_o,
  output logic [sha256_pkg::WordW-1:0]   digest_word_4_o,
  output logic [sha256_pkg::WordW-1:0]   digest_word_5_o,
  output logic [sha256_pkg::WordW-1:0]   digest_word_6_o,
  output logic [sha256_pkg::WordW-1:0]   digest_word_7_o
);

  sha256_pkg::item_t            push_item, pop_item;
  logic                         push, pop, full, empty;
  logic [sha256_pkg::WordW-1:0] digest [sha256_pkg::NumChain];

  sha256_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .message_word_i (message_word_i),
    .new_message_i  (new_message_i),
    .queue_full_i   (full),
    .busy_o         (busy_o),
    .push_o         (push),
    .push_item_o    (push_item)
  );

  sha256_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (full),
    .pop_i       (pop),
    .pop_item_o  (pop_item),
    .empty_o     (empty)
  );

  sha256_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .queue_empty_i (empty),
    .queue_item_i  (pop_item),
    .pop_o         (pop),
    .done_o        (done_o),
    .digest_o      (digest)
  );

  assign digest_word_0_o = digest[0];
  assign digest_word_1_o = digest[1];
  assign digest_word_2_o = digest[2];
  assign digest_word_3_o = digest[3];
  assign digest_word_4_o = digest[4];
  assign digest_word_5_o = digest[5];
  assign digest_word_6_o = digest[6];
  assign digest_word_7_o = digest[7];

endmodule

// ===== design/sha256_front.sv =====
// Front end of the SHA-256 unit: accepts message word requests and tags each one
// with its place in the block. Depends on sha256_pkg.
module sha256_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [sha256_pkg::WordW-1:0] message_word_i,
  input  logic                         new_message_i,
  input  logic                         queue_full_i,
  output logic                         busy_o,
  output logic                         push_o,
  output sha256_pkg::item_t            push_item_o
);

  logic [sha256_pkg::CountW-1:0] count_q, count_d;
  logic [sha256_pkg::CountW-1:0] slot;

  assign busy_o = queue_full_i;
  assign push_o = start_i && !queue_full_i;

  // A new message always restarts the block, dropping any partial words.
  assign slot    = new_message_i ? '0 : count_q;
  assign count_d = slot + sha256_pkg::CountW'(1);

  assign push_item_o.word  = message_word_i;
  assign push_item_o.first = new_message_i;
  assign push_item_o.last  = (slot == sha256_pkg::LastWordIdx);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (push_o) begin
      count_q <= count_d;
    end
  end

endmodule

// ===== design/sha256_fifo.sv =====
// Short request queue between the front end and the compression core.
// Depends on sha256_pkg for the item type.
module sha256_fifo #(
  parameter int unsigned Depth = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  sha256_pkg::item_t push_item_i,
  output logic              full_o,
  input  logic              pop_i,
  output sha256_pkg::item_t pop_item_o,
  output logic              empty_o
);

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);
  localparam logic [CntW-1:0]  FullCnt  = CntW'(Depth);

  sha256_pkg::item_t mem_q [Depth];

  logic [AddrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign full_o     = (cnt_q == FullCnt);
  assign empty_o    = (cnt_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_item_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == LastAddr) ? '0 : wptr_q + AddrW'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == LastAddr) ? '0 : rptr_q + AddrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

// ===== design/sha256_core.sv =====
// Compression core: gathers queued words into the schedule window, runs one round per
// cycle and folds the result into the chaining value. Depends on sha256_pkg.
module sha256_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [sha256_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [sha256_pkg::WordW-1:0]   cfg_wdata_i,
  input  logic                           queue_empty_i,
  input  sha256_pkg::item_t              queue_item_i,
  output logic                           pop_o,
  output logic                           done_o,
  output logic [sha256_pkg::WordW-1:0]   digest_o [sha256_pkg::NumChain]
);

  typedef enum logic [1:0] {
    IDLE,
    ROUNDS,
    FINISH
  } state_e;

  state_e                        state_q;
  logic [sha256_pkg::RoundW-1:0] round_q;
  logic                          done_q;
  logic [sha256_pkg::WordW-1:0]  iv_q    [sha256_pkg::NumChain];
  logic [sha256_pkg::WordW-1:0]  chain_q [sha256_pkg::NumChain];
  logic [sha256_pkg::WordW-1:0]  work_q  [sha256_pkg::NumChain];
  logic [sha256_pkg::WordW-1:0]  work_d  [sha256_pkg::NumChain];
  logic [sha256_pkg::WordW-1:0]  win_q   [sha256_pkg::BlockWords];
  logic [sha256_pkg::WordW-1:0]  digest_q [sha256_pkg::NumChain];
  logic [sha256_pkg::WordW-1:0]  sum_d   [sha256_pkg::NumChain];
  logic [sha256_pkg::WordW-1:0]  w_next, t1, t2, ch, mj;

  assign pop_o    = (state_q == IDLE) && !queue_empty_i;
  assign done_o   = done_q;
  assign digest_o = digest_q;

  // The window holds w[r] .. w[r+15]; its oldest word feeds the current round.
  assign w_next = sha256_pkg::small_sigma1(win_q[14]) + win_q[9]
                + sha256_pkg::small_sigma0(win_q[1]) + win_q[0];

  always_comb begin
    ch = (work_q[4] & work_q[5]) ^ (~work_q[4] & work_q[6]);
    mj = (work_q[0] & work_q[1]) ^ (work_q[0] & work_q[2]) ^ (work_q[1] & work_q[2]);
    t1 = work_q[7] + sha256_pkg::big_sigma1(work_q[4]) + ch
       + sha256_pkg::RoundK[round_q] + win_q[0];
    t2 = sha256_pkg::big_sigma0(work_q[0]) + mj;
    work_d[7] = work_q[6];
    work_d[6] = work_q[5];
    work_d[5] = work_q[4];
    work_d[4] = work_q[3] + t1;
    work_d[3] = work_q[2];
    work_d[2] = work_q[1];
    work_d[1] = work_q[0];
    work_d[0] = t1 + t2;
    for (int i = 0; i < sha256_pkg::NumChain; i++) begin
      sum_d[i] = chain_q[i] + work_q[i];
    end
  end

  // Schedule window and working variables.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      for (int i = 0; i < sha256_pkg::BlockWords - 1; i++) begin
        win_q[i] <= win_q[i + 1];
      end
      win_q[sha256_pkg::BlockWords - 1] <= queue_item_i.word;
      if (queue_item_i.last) begin
        work_q <= chain_q;
      end
    end else if (state_q == ROUNDS) begin
      for (int i = 0; i < sha256_pkg::BlockWords - 1; i++) begin
        win_q[i] <= win_q[i + 1];
      end
      win_q[sha256_pkg::BlockWords - 1] <= w_next;
      work_q <= work_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= IDLE;
      round_q  <= '0;
      done_q   <= 1'b0;
      iv_q     <= sha256_pkg::IvReset;
      chain_q  <= sha256_pkg::IvReset;
      digest_q <= sha256_pkg::IvReset;
    end else begin
      done_q <= 1'b0;
      if (cfg_we_i) begin
        iv_q[cfg_index_i] <= cfg_wdata_i;
      end
      case (state_q)
        IDLE: begin
          if (pop_o) begin
            if (queue_item_i.first) begin
              chain_q <= iv_q;
            end
            if (queue_item_i.last) begin
              round_q <= '0;
              state_q <= ROUNDS;
            end
          end
        end
        ROUNDS: begin
          round_q <= round_q + sha256_pkg::RoundW'(1);
          if (round_q == sha256_pkg::LastRound) begin
            state_q <= FINISH;
          end
        end
        FINISH: begin
          chain_q  <= sum_d;
          digest_q <= sum_d;
          done_q   <= 1'b1;
          state_q  <= IDLE;
        end
        default: begin
          state_q <= IDLE;
        end
      endcase
    end
  end

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for sha256_block_compression: message words in, chaining digests out.
// Keeps its own SHA-256 compression predictor and a queue of expected digests.
// Depends on sha256_pkg for port widths and the number of chaining words only.
module testbench;

  localparam int unsigned WordW   = sha256_pkg::WordW;
  localparam int unsigned CfgIdxW = sha256_pkg::CfgIdxW;
  localparam int unsigned NumIv   = sha256_pkg::NumChain;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainCycles = 100;
  localparam int unsigned MaxReports = 10;
  localparam int unsigned NumPhases = 6;

  typedef logic [WordW-1:0] word_t;
  typedef logic [0:7][WordW-1:0] digest_t;
  typedef logic [0:15][WordW-1:0] block_t;

  typedef struct packed {
    word_t   word;
    logic    new_msg;
    logic    known;
    digest_t digest;
  } dir_row_t;

  localparam digest_t StdIv = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t RoundConst [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // The first block is the padded message "abc" sent without a new-message flag, so it
  // must hash from the reset chaining value. The tail restarts a message in mid-block.
  localparam int unsigned NumDirRows = 22;
  localparam dir_row_t DirRows [NumDirRows] = '{
    '{32'h61626380, 1'b0, 1'b0, '0},
    '{32'h00000000, 1'b0, 1'b0, '0},
    '{32'h00000000, 1'b0, 1'b0, '0},
    '{32'h00000000, 1'b0, 1'b0, '0},
    '{32'h00000000, 1'b0, 1'b0, '0},
    '{32'h00000000, 1'b0, 1'b0, '0},
    '{32'h00000000, 1'b0, 1'b0, '0},
    '{32'h00000000, 1'b0, 1'b0, '0},
    '{32'h00000000, 1'b0, 1'b0, '0},
    '{32'h00000000, 1'b0, 1'b0, '0},
    '{32'h00000000, 1'b0, 1'b0, '0},
    '{32'h00000000, 1'b0, 1'b0, '0},
    '{32'h00000000, 1'b0, 1'b0, '0},
    '{32'h00000000, 1'b0, 1'b0, '0},
    '{32'h00000000, 1'b0, 1'b0, '0},
    '{32'h00000018, 1'b0, 1'b1, {32'hba7816bf, 32'h8f01cfea, 32'h414140de, 32'h5dae2223,
                                 32'hb00361a3, 32'h96177a9c, 32'hb410ff61, 32'hf20015ad}},
    '{32'hffffffff, 1'b0, 1'b0, '0},
    '{32'h00000000, 1'b0, 1'b0, '0},
    '{32'h80000000, 1'b1, 1'b0, '0},
    '{32'h00000001, 1'b0, 1'b0, '0},
    '{32'hffffffff, 1'b0, 1'b0, '0},
    '{32'h7fffffff, 1'b0, 1'b0, '0}
  };

  logic    clk_i;
  logic    rst_ni = 1'b0;
  logic    start_i = 1'b0;
  word_t   message_word_i = '0;
  logic    new_message_i = 1'b0;
  logic    cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  word_t   cfg_wdata_i = '0;
  logic    busy_o;
  logic    done_o;
  word_t   digest_word_0_o, digest_word_1_o, digest_word_2_o, digest_word_3_o;
  word_t   digest_word_4_o, digest_word_5_o, digest_word_6_o, digest_word_7_o;

  // Predictor state.
  digest_t     iv_regs = StdIv;
  digest_t     chain_words = StdIv;
  block_t      block_buf = '0;
  logic [3:0]  word_pos = '0;

  digest_t     digest_fifo [$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned msg_blocks_left = 0;
  bit          idle_on = 1'b1;

  sha256_block_compression dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .message_word_i  (message_word_i),
    .new_message_i   (new_message_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .done_o          (done_o),
    .digest_word_0_o (digest_word_0_o),
    .digest_word_1_o (digest_word_1_o),
    .digest_word_2_o (digest_word_2_o),
    .digest_word_3_o (digest_word_3_o),
    .digest_word_4_o (digest_word_4_o),
    .digest_word_5_o (digest_word_5_o),
    .digest_word_6_o (digest_word_6_o),
    .digest_word_7_o (digest_word_7_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic word_t rotr(input word_t x, input int n);
    return (x >> n) | (x << (WordW - n));
  endfunction

  function automatic digest_t compress(input digest_t h, input block_t blk);
    word_t   w [64];
    word_t   a, b, c, d, e, f, g, k, t1, t2, ch, mj;
    digest_t res;
    for (int r = 0; r < 16; r++) w[r] = blk[r];
    for (int r = 16; r < 64; r++) begin
      w[r] = (rotr(w[r-2], 17) ^ rotr(w[r-2], 19) ^ (w[r-2] >> 10)) + w[r-7]
           + (rotr(w[r-15], 7) ^ rotr(w[r-15], 18) ^ (w[r-15] >> 3)) + w[r-16];
    end
    {a, b, c, d, e, f, g, k} = h;
    for (int r = 0; r < 64; r++) begin
      ch = (e & f) ^ (~e & g);
      mj = (a & b) ^ (a & c) ^ (b & c);
      t1 = k + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ch + RoundConst[r] + w[r];
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + mj;
      k = g;
      g = f;
      f = e;
      e = d + t1;
      d = c;
      c = b;
      b = a;
      a = t1 + t2;
    end
    res = {a, b, c, d, e, f, g, k};
    for (int i = 0; i < 8; i++) res[i] = res[i] + h[i];
    return res;
  endfunction

  // Takes one accepted word; returns 1 with the new chaining value when a block completes.
  function automatic bit absorb_word(input word_t w, input bit nm, output digest_t dig);
    if (nm) begin
      chain_words = iv_regs;
      word_pos = '0;
    end
    block_buf[word_pos] = w;
    word_pos = word_pos + 4'd1;
    dig = chain_words;
    if (word_pos != '0) return 1'b0;
    chain_words = compress(chain_words, block_buf);
    dig = chain_words;
    return 1'b1;
  endfunction

  function automatic word_t pick_word();
    word_t w;
    case ($urandom_range(15))
      0: w = '1;
      1: w = '0;
      2: w = word_t'(1) << $urandom_range(WordW - 1);
      3: w = ~(word_t'(1) << $urandom_range(WordW - 1));
      default: w = $urandom;
    endcase
    return w;
  endfunction

  // Mostly well-formed messages of one to three blocks; now and then a message that just
  // keeps chaining, or a stray restart in the middle of a block.
  function automatic bit pick_new_message();
    bit nm;
    if (word_pos == '0 && msg_blocks_left == 0) begin
      msg_blocks_left = $urandom_range(1, 3);
      nm = ($urandom_range(7) != 0);
    end else begin
      nm = ($urandom_range(39) == 0);
    end
    return nm;
  endfunction

  function automatic digest_t phase_iv(input int p);
    digest_t v;
    case (p)
      0: v = '0;
      1: v = '1;
      3: for (int i = 0; i < 8; i++) v[i] = (i % 2 == 0) ? '0 : '1;
      NumPhases - 1: v = StdIv;
      default: for (int i = 0; i < 8; i++) v[i] = $urandom;
    endcase
    return v;
  endfunction

  task automatic send_word(input word_t w, input bit nm, input bit known, input digest_t kdig);
    digest_t dig;
    message_word_i <= w;
    new_message_i  <= nm;
    start_i        <= 1'b1;
    do @(posedge clk_i); while (busy_o);
    if (absorb_word(w, nm, dig)) digest_fifo.push_back(known ? kdig : dig);
  endtask

  // Waits until every expected digest has come and the request queue has had time to drain.
  task automatic settle();
    start_i <= 1'b0;
    while (digest_fifo.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic load_ivs(input digest_t v);
    cfg_we_i <= 1'b1;
    for (int i = 0; i < NumIv; i++) begin
      cfg_index_i <= CfgIdxW'(i);
      cfg_wdata_i <= v[i];
      @(posedge clk_i);
      iv_regs[i] = v[i];
    end
    cfg_we_i <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    digest_t got, want;
    if (rst_ni && done_o) begin
      got = {digest_word_0_o, digest_word_1_o, digest_word_2_o, digest_word_3_o,
             digest_word_4_o, digest_word_5_o, digest_word_6_o, digest_word_7_o};
      if (digest_fifo.size() == 0) begin
        if (mismatches < MaxReports) $display("unexpected digest %h", got);
        mismatches++;
      end else begin
        want = digest_fifo.pop_front();
        for (int i = 0; i < 8; i++) begin
          if (got[i] !== want[i]) begin
            if (mismatches < MaxReports) begin
              $display("digest word %0d: expected %h, got %h", i, want[i], got[i]);
            end
            mismatches++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int unsigned phase_items [NumPhases];
    word_t w;
    bit    nm;
    phase_items = '{200, 220, 240, 220, 240, 280};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < NumDirRows; r++) begin
      send_word(DirRows[r].word, DirRows[r].new_msg, DirRows[r].known, DirRows[r].digest);
    end

    // A phase may begin in the middle of a message, so the chaining value must survive
    // the register writes until the next new-message word.
    for (int p = 0; p < NumPhases; p++) begin
      settle();
      load_ivs(phase_iv(p));
      idle_on = (p != 2);
      for (int n = 0; n < phase_items[p]; n++) begin
        nm = pick_new_message();
        w  = pick_word();
        send_word(w, nm, 1'b0, '0);
        if (word_pos == '0 && msg_blocks_left > 0) msg_blocks_left--;
        if (idle_on && $urandom_range(99) < 26) begin
          start_i <= 1'b0;
          repeat ($urandom_range(1, 4)) @(posedge clk_i);
        end
      end
    end

    settle();
    if (mismatches == 0 && digest_fifo.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
